>>> rtl/core/pkc_pkg.sv
// shared types and constants of the packed k-mer partition counter
`default_nettype none

package pkc_pkg;

  // stream geometry
  localparam int WORD_BITS   = 32;
  localparam int BASE_BITS   = 2;
  localparam int LANES       = WORD_BITS / BASE_BITS;
  localparam int KEYS        = LANES + 1;
  localparam int PREFIX_BITS = 16;
  localparam int RINDEX_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int TDATA_BITS  = WORD_BITS + RINDEX_BITS;
  localparam int OUT_BITS    = COUNT_BITS + RINDEX_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // operation codes carried in tuser
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // requests from the front end to the count engine
  typedef struct packed {
    logic feed;
    logic read;
    logic out_free;
  } pkc_req_t;

  // status back from the count engine
  typedef struct packed {
    logic                  busy;
    logic                  rd_valid;
    logic [COUNT_BITS-1:0] rd_data;
  } pkc_status_t;

endpackage

`default_nettype wire

>>> rtl/core/pkc_key_lane.sv
// one key lane: prefix match and counter slot of a 16-base key
`default_nettype none

module pkc_key_lane #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic [pkc_pkg::WORD_BITS-1:0]   key,
  input  wire logic                            enable,
  input  wire logic [pkc_pkg::PREFIX_BITS-1:0] prefix,
  output logic                                 hit,
  output logic [INDEX_BITS-1:0]                slot
);

  logic [pkc_pkg::WORD_BITS-1:0] key_top;

  // top bits of the key against the partition prefix
  assign key_top = key >> INDEX_BITS;
  assign hit     = enable && (key_top == pkc_pkg::WORD_BITS'(prefix));
  assign slot    = key[INDEX_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/core/pkc_count_engine.sv
// counter memory with clearing pass, hit walker and read port
`default_nettype none

module pkc_count_engine #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire pkc_pkg::pkc_req_t                           req,
  input  wire logic [pkc_pkg::KEYS-1:0]                    hits,
  input  wire logic [pkc_pkg::KEYS-1:0][INDEX_BITS-1:0]    slots,
  input  wire logic [INDEX_BITS-1:0]                       query_addr,
  output pkc_pkg::pkc_status_t                             status
);

  localparam int DEPTH = 1 << INDEX_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;

  logic [pkc_pkg::COUNT_BITS-1:0] mem [DEPTH];
  logic [pkc_pkg::COUNT_BITS-1:0] mem_q;

  logic [2:0]                                     state;
  logic [2:0]                                     state_next;
  logic [INDEX_BITS-1:0]                          clr_addr;
  logic [pkc_pkg::KEYS-1:0]                       pend_mask;
  logic [pkc_pkg::KEYS-1:0][INDEX_BITS-1:0]       pend_slots;
  logic [INDEX_BITS-1:0]                          q_addr;
  logic                                           rd_pend;
  logic [INDEX_BITS-1:0]                          rd_addr;
  logic                                           fwd_valid;
  logic [INDEX_BITS-1:0]                          fwd_addr;
  logic [pkc_pkg::COUNT_BITS-1:0]                 fwd_data;

  logic [pkc_pkg::KEYS-1:0]       low_bit;
  logic [INDEX_BITS-1:0]          pick_slot;
  logic [pkc_pkg::COUNT_BITS-1:0] old_count;
  logic [pkc_pkg::COUNT_BITS-1:0] new_count;
  logic                           mem_re;
  logic [INDEX_BITS-1:0]          mem_raddr;
  logic                           mem_we;
  logic [INDEX_BITS-1:0]          mem_waddr;
  logic [pkc_pkg::COUNT_BITS-1:0] mem_wdata;

  // lowest pending hit and its slot
  always_comb begin
    low_bit   = pend_mask & (~pend_mask + pkc_pkg::KEYS'(1));
    pick_slot = '0;
    for (int i = 0; i < pkc_pkg::KEYS; i++) begin
      if (low_bit[i]) begin
        pick_slot = pick_slot | pend_slots[i];
      end
    end
  end

  // saturating increment, forwarding the write of the issue cycle
  always_comb begin
    old_count = (fwd_valid && (fwd_addr == rd_addr)) ? fwd_data : mem_q;
    new_count = (old_count == pkc_pkg::COUNT_MAX) ? old_count
                                                  : old_count + 32'd1;
  end

  // memory port control and next state
  always_comb begin
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.feed) begin
          state_next = S_WALK;
        end else if (req.read) begin
          state_next = S_READ;
        end
      end
      S_WALK: begin
        mem_re    = |pend_mask;
        mem_raddr = pick_slot;
        mem_we    = rd_pend;
        mem_waddr = rd_addr;
        mem_wdata = new_count;
        // the last write-back lands in this cycle
        if (!(|pend_mask)) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        mem_re    = req.out_free;
        mem_raddr = q_addr;
        if (req.out_free) begin
          state_next = S_RDATA;
        end
      end
      S_RDATA: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // counter storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pend_mask <= '0;
      rd_pend   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + INDEX_BITS'(1);
      end
      if (state == S_IDLE) begin
        pend_mask <= req.feed ? hits : '0;
        rd_pend   <= 1'b0;
        fwd_valid <= 1'b0;
      end else if (state == S_WALK) begin
        pend_mask <= pend_mask & ~low_bit;
        rd_pend   <= |pend_mask;
        fwd_valid <= rd_pend;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      pend_slots <= slots;
      q_addr     <= query_addr;
    end
    if (state == S_WALK) begin
      rd_addr  <= pick_slot;
      fwd_addr <= rd_addr;
      fwd_data <= new_count;
    end
  end

  assign status.busy     = (state != S_IDLE);
  assign status.rd_valid = (state == S_RDATA);
  assign status.rd_data  = mem_q;

endmodule

`default_nettype wire

>>> rtl/core/packed_kmer_partition_counter.sv
// top level of the packed k-mer partition counter
// Input words arrive on the s_ channel; tuser selects the operation:
// feed (tuser 0) takes a word of sixteen 2-bit bases, first base in the
// top bits, with tlast marking the last word of a sequence; read (tuser 1)
// returns the counter at read_index on the m_ channel.
// The cfg channel writes the 16-bit partition prefix; it is always ready.
// A feed word fans out to seventeen key lanes in the accept cycle; each
// matching key then costs one cycle on the counter memory (pipelined
// read-modify-write with forwarding), and s_tready stays low until the
// last write-back of the word has landed.
// A read goes through the engine states S_READ, which reads the memory,
// and S_RDATA, which loads its result word into the output register.
// While that register is held by a stalled receiver, a following read
// waits in the engine before touching the memory, with s_tready low;
// feed words ahead of it are still accepted.
// After reset the block sweeps the counter memory to zero, one entry a
// cycle, with s_tready low; cfg writes are taken.
`default_nettype none

module packed_kmer_partition_counter #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // s_tdata: packed_word [31:0], read_index [47:32]
  input  wire logic [pkc_pkg::TDATA_BITS-1:0]    s_tdata,
  // s_tuser: operation
  input  wire logic                              s_tuser,
  input  wire logic                              s_tlast,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // m_tdata: count_value [31:0], count_index [47:32]
  output logic [pkc_pkg::OUT_BITS-1:0]           m_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic [pkc_pkg::PREFIX_BITS-1:0]   cfg_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready
);

  logic [pkc_pkg::PREFIX_BITS-1:0]             partition_prefix;
  logic [pkc_pkg::WORD_BITS-1:0]               previous_word;
  logic                                        have_previous;
  logic [pkc_pkg::RINDEX_BITS-1:0]             rd_index;
  logic [pkc_pkg::RINDEX_BITS-1:0]             count_index;
  logic [pkc_pkg::COUNT_BITS-1:0]              count_value;

  logic [pkc_pkg::WORD_BITS-1:0]               in_word;
  logic [pkc_pkg::RINDEX_BITS-1:0]             in_index;
  logic [2*pkc_pkg::WORD_BITS-1:0]             joined;
  logic [pkc_pkg::KEYS-1:0]                    hits;
  logic [pkc_pkg::KEYS-1:0][INDEX_BITS-1:0]    slots;
  logic                                        accept;
  pkc_pkg::pkc_req_t                           req;
  pkc_pkg::pkc_status_t                        status;

  assign in_word  = s_tdata[pkc_pkg::WORD_BITS-1:0];
  assign in_index = s_tdata[pkc_pkg::TDATA_BITS-1:pkc_pkg::WORD_BITS];
  assign joined   = {previous_word, in_word};

  // configuration write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_prefix <= '0;
    end else if (cfg_valid && cfg_ready) begin
      partition_prefix <= cfg_data;
    end
  end

  // key lanes over the word pair
  for (genvar i = 0; i < pkc_pkg::LANES; i++) begin : g_lane
    pkc_key_lane #(
      .INDEX_BITS(INDEX_BITS)
    ) u_lane (
      .key   (joined[2*pkc_pkg::WORD_BITS-1-pkc_pkg::BASE_BITS*i -: pkc_pkg::WORD_BITS]),
      .enable(have_previous),
      .prefix(partition_prefix),
      .hit   (hits[i]),
      .slot  (slots[i])
    );
  end

  // extra lane for the offset-0 key of a last word
  pkc_key_lane #(
    .INDEX_BITS(INDEX_BITS)
  ) u_last_lane (
    .key   (in_word),
    .enable(s_tlast),
    .prefix(partition_prefix),
    .hit   (hits[pkc_pkg::LANES]),
    .slot  (slots[pkc_pkg::LANES])
  );

  // input handshake
  assign s_tready     = !status.busy;
  assign accept       = s_tvalid && s_tready;
  assign req.feed     = accept && (s_tuser == pkc_pkg::OP_FEED);
  assign req.read     = accept && (s_tuser == pkc_pkg::OP_READ);
  assign req.out_free = !m_tvalid || m_tready;

  pkc_count_engine #(
    .INDEX_BITS(INDEX_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .hits      (hits),
    .slots     (slots),
    .query_addr(INDEX_BITS'(in_index)),
    .status    (status)
  );

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_word <= '0;
      have_previous <= 1'b0;
    end else if (req.feed) begin
      previous_word <= s_tlast ? '0 : in_word;
      have_previous <= !s_tlast;
    end
  end

  // index of the read in the engine
  always_ff @(posedge clk) begin
    if (req.read) begin
      rd_index <= in_index;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (status.rd_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.rd_valid) begin
      count_value <= status.rd_data;
      count_index <= rd_index;
    end
  end

  assign m_tdata = {count_index, count_value};

endmodule

`default_nettype wire

>>> test/tb_packed_kmer_partition_counter.sv
// testbench for the packed k-mer partition counter: directed and random streams checked against a count table
`timescale 1ns / 1ps

module tb_packed_kmer_partition_counter;

  localparam int INDEX_BITS = 16;
  localparam int TABLE_SIZE = 1 << INDEX_BITS;
  localparam logic [31:0] IDX_MASK = 32'(TABLE_SIZE - 1);
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 320;

  // keeps its own counter table and sequence state, queues expected read words
  class kmer_count_board;
    bit [31:0] tally [TABLE_SIZE];
    bit [15:0] prefix;
    bit [31:0] prev_word;
    bit        have_prev;
    bit [pkc_pkg::OUT_BITS-1:0] expected_counts [$];
    bit [15:0] recent_slots [$];
    int        errors;

    function void set_prefix(bit [15:0] value);
      prefix = value;
    endfunction

    // one key: count it when its upper bits match the partition
    function void count_key(bit [31:0] key);
      bit [31:0] slot;
      if ((key >> INDEX_BITS) == 32'(prefix)) begin
        slot = key & IDX_MASK;
        if (tally[slot] != pkc_pkg::COUNT_MAX) tally[slot] = tally[slot] + 1;
        recent_slots.push_back(slot[15:0]);
        if (recent_slots.size() > 64) void'(recent_slots.pop_front());
      end
    endfunction

    // accepted input word
    function void note_word(bit op, bit [31:0] word, bit last, bit [15:0] rindex);
      bit [63:0] joined;
      if (op == pkc_pkg::OP_READ) begin
        expected_counts.push_back({rindex, tally[32'(rindex) & IDX_MASK]});
        return;
      end
      if (have_prev) begin
        joined = {prev_word, word};
        for (int s = 0; s < 16; s++) count_key(joined[63-2*s -: 32]);
      end
      if (last) begin
        count_key(word);
        prev_word = '0;
        have_prev = 1'b0;
      end else begin
        prev_word = word;
        have_prev = 1'b1;
      end
    endfunction

    // accepted result word against the oldest expectation
    function void check_count(bit [pkc_pkg::OUT_BITS-1:0] got);
      bit [pkc_pkg::OUT_BITS-1:0] want;
      if (expected_counts.size() == 0) begin
        $error("unexpected result word: count_value %0h count_index %0h",
               got[31:0], got[47:32]);
        errors++;
        return;
      end
      want = expected_counts.pop_front();
      if (got[31:0] != want[31:0]) begin
        $error("count_value mismatch: expected %0h, actual %0h", want[31:0], got[31:0]);
        errors++;
      end
      if (got[47:32] != want[47:32]) begin
        $error("count_index mismatch: expected %0h, actual %0h", want[47:32], got[47:32]);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_counts.size();
    endfunction

    // mostly read slots that were just counted
    function bit [15:0] pick_index();
      if (recent_slots.size() > 0 && $urandom_range(0, 9) < 7)
        return recent_slots[$urandom_range(0, recent_slots.size() - 1)];
      return 16'($urandom);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic [pkc_pkg::TDATA_BITS-1:0] s_tdata;
  logic s_tuser;
  logic s_tlast;
  logic s_tvalid;
  logic s_tready;
  logic [pkc_pkg::OUT_BITS-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [pkc_pkg::PREFIX_BITS-1:0] cfg_data;
  logic cfg_valid;
  logic cfg_ready;

  kmer_count_board board = new();
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  always #6 clk = ~clk;

  packed_kmer_partition_counter #(.INDEX_BITS(INDEX_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_data(cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // base words biased toward keys of the current partition
  function automatic bit [31:0] make_word(bit [15:0] p);
    bit [31:0] w;
    bit [1:0] b;
    case ($urandom_range(0, 5))
      0: w = {p, 16'($urandom)};
      1: w = {p, p};
      2: w = $urandom;
      3: w = {16'($urandom), p};
      4: w = {p, 16'($urandom)} ^ (32'd1 << $urandom_range(0, 31));
      default: begin
        b = 2'($urandom);
        w = {16{b}};
      end
    endcase
    return w;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input bit op, input bit [31:0] word, input bit last,
                           input bit [15:0] rindex);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {rindex, word};
    s_tuser = op;
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
    board.note_word(op, word, last, rindex);
    @(negedge clk);
  endtask

  task automatic read_count(input bit [15:0] rindex);
    send_item(pkc_pkg::OP_READ, $urandom, 1'($urandom), rindex);
  endtask

  task automatic feed_word(input bit [31:0] word, input bit last);
    send_item(pkc_pkg::OP_FEED, word, last, 16'($urandom));
  endtask

  // stop offering, wait for every result, then let the count engine settle
  task automatic drain();
    s_tvalid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_prefix(input bit [15:0] value);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_prefix(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random sequences of feed words with reads mixed in
  task automatic run_phase(input bit [15:0] p, input bit steady, input bit squeeze);
    int left;
    int burst;
    bit last;
    bit [31:0] w;
    left = 0;
    burst = 0;
    drain();
    write_prefix(p);
    no_gaps = steady;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // receiver holds off while a run of reads backs the block up
      if (squeeze && i == PHASE_ITEMS / 2) begin
        hold_req = 1'b1;
        burst = 40;
      end
      if (squeeze && i == 3 * PHASE_ITEMS / 4) drain();
      if (burst > 0) begin
        burst--;
        read_count(board.pick_index());
      end else if ($urandom_range(0, 3) == 0) begin
        read_count(board.pick_index());
      end else begin
        if (left == 0) left = $urandom_range(1, 6);
        w = ($urandom_range(0, 9) == 0) ? $urandom : make_word(p);
        last = (left == 1);
        // occasionally a broken sequence
        if ($urandom_range(0, 19) == 0) last = ~last;
        left = last ? 0 : left - 1;
        feed_word(w, last);
      end
    end
    no_gaps = 1'b0;
  endtask

  // receiver ready pattern, with a long hold-off on request
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        m_tready = 1'b1;
        run_left--;
      end else begin
        stall_left = pick_gap();
        run_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 8);
        m_tready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // result words checked at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_count(m_tdata);
  end

  // main stimulus
  initial begin
    rst = 1'b1;
    s_tdata = '0;
    s_tuser = pkc_pkg::OP_FEED;
    s_tlast = 1'b0;
    s_tvalid = 1'b0;
    cfg_data = '0;
    cfg_valid = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_prefix(16'h0000);

    // cleared table at both index extremes
    read_count(16'h0000);
    read_count(16'hFFFF);
    // single final word counts its own key
    feed_word(32'h0000_1234, 1'b1);
    read_count(16'h1234);
    // read in the middle of a sequence, then a full pair of zero words
    feed_word(32'h0000_0000, 1'b0);
    read_count(16'h0000);
    feed_word(32'h0000_0000, 1'b1);
    read_count(16'h0000);
    // all-ones words miss partition zero
    feed_word(32'hFFFF_FFFF, 1'b0);
    feed_word(32'hFFFF_FFFF, 1'b1);
    read_count(16'hFFFF);
    // three-word sequence
    feed_word(32'h0000_0001, 1'b0);
    feed_word(32'h0000_0002, 1'b0);
    feed_word(32'h1234_5678, 1'b1);
    read_count(16'h0001);
    read_count(16'h0002);

    // top partition
    drain();
    write_prefix(16'hFFFF);
    feed_word(32'hFFFF_FFFF, 1'b0);
    feed_word(32'hFFFF_FFFF, 1'b1);
    read_count(16'hFFFF);
    feed_word(32'hFFFF_0000, 1'b1);
    read_count(16'h0000);

    run_phase(16'h0000, 1'b0, 1'b0);
    run_phase(16'hFFFF, 1'b1, 1'b0);
    run_phase(16'($urandom), 1'b0, 1'b1);
    run_phase(16'h5555, 1'b0, 1'b0);
    run_phase(16'($urandom), 1'b0, 1'b0);
    run_phase(16'h0000, 1'b0, 1'b0);

    s_tvalid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
